// ----- src/cdad_pkg.sv -----
// Shared types, constants and the month length function for the date adder.
package cdad_pkg;

    localparam int DAY_W       = 5;
    localparam int MONTH_W     = 4;
    localparam int YEAR_W      = 14;
    localparam int OFFSET_W    = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 14;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;
    localparam int REM_W       = 14;
    localparam int CENT_CNT_W  = 2;

    localparam int OFFSET_BITS_DEFAULT = 16;

    localparam logic [YEAR_W-1:0] YEAR_MAX    = 14'd16383;
    localparam logic [REM_W-1:0]  CENTURY     = 14'd100;
    localparam logic [REM_W-1:0]  CENTURY_END = 14'd99;

    localparam logic [DAY_W-1:0]   BASE_DAY_RST   = 5'd1;
    localparam logic [MONTH_W-1:0] BASE_MONTH_RST = 4'd1;
    localparam logic [YEAR_W-1:0]  BASE_YEAR_RST  = 14'd2000;

    localparam logic [MONTH_W-1:0] MONTH_NONE = 4'd0;
    localparam logic [MONTH_W-1:0] JAN = 4'd1;
    localparam logic [MONTH_W-1:0] FEB = 4'd2;
    localparam logic [MONTH_W-1:0] APR = 4'd4;
    localparam logic [MONTH_W-1:0] JUN = 4'd6;
    localparam logic [MONTH_W-1:0] SEP = 4'd9;
    localparam logic [MONTH_W-1:0] NOV = 4'd11;
    localparam logic [MONTH_W-1:0] DEC = 4'd12;

    localparam logic [DAY_W-1:0] LEN_31 = 5'd31;
    localparam logic [DAY_W-1:0] LEN_30 = 5'd30;
    localparam logic [DAY_W-1:0] LEN_29 = 5'd29;
    localparam logic [DAY_W-1:0] LEN_28 = 5'd28;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_DAY   = 2'd0,
        REG_BASE_MONTH = 2'd1,
        REG_BASE_YEAR  = 2'd2
    } cfg_reg_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        len = LEN_31;
        case (m) inside
            FEB:                len = leap ? LEN_29 : LEN_28;
            APR, JUN, SEP, NOV: len = LEN_30;
            default:            len = LEN_31;
        endcase
        return len;
    endfunction

endpackage

// ----- src/cdad_sub.sv -----
// Shared subtractor with borrow out, used for century reduction and month steps.
module cdad_sub #(
    parameter int W = 17
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] diff,
    output logic         borrow
);

    assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

// ----- src/calendar_date_add_days.sv -----
// Top level of the calendar date adder: config registers, sequencer and output stage.
//
// Adds day_offset to the base date held in the configuration registers and returns
// the Gregorian date that results. A single subtractor is shared by two phases,
// first reducing the base year by 100 per cycle to find its place in the 400-year
// leap cycle, then stripping one whole month per cycle from the running day count.
// The input side is ready only while the sequencer is idle; a finished result waits
// in the output register, and the next item may be taken while it waits. The user
// must write the configuration registers only while the block is idle; the block
// itself does not enforce this.
module calendar_date_add_days #(
    parameter int OFFSET_BITS = cdad_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [cdad_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cdad_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cdad_pkg::S_TDATA_W-1:0]   s_tdata,   // [15:0] day_offset
    // output stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cdad_pkg::M_TDATA_W-1:0]   m_tdata    // [4:0] result_day,
                                                        // [8:5] result_month,
                                                        // [22:9] result_year, [23] zero
);

    // Offset bits actually used, and the day count width they imply.
    localparam int OFF_USED = (OFFSET_BITS < cdad_pkg::OFFSET_W) ? OFFSET_BITS
                                                                 : cdad_pkg::OFFSET_W;
    localparam int CNT_W    = OFF_USED + 1;
    localparam int SUB_W    = (CNT_W > cdad_pkg::REM_W) ? CNT_W : cdad_pkg::REM_W;
    localparam logic [cdad_pkg::OFFSET_W-1:0] OFF_MASK =
        cdad_pkg::OFFSET_W'((17'(1) << OFF_USED) - 17'(1));

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_STEP
    } state_t;

    // Configuration registers
    logic [cdad_pkg::DAY_W-1:0]   base_day_reg;
    logic [cdad_pkg::MONTH_W-1:0] base_month_reg;
    logic [cdad_pkg::YEAR_W-1:0]  base_year_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_day_reg   <= cdad_pkg::BASE_DAY_RST;
            base_month_reg <= cdad_pkg::BASE_MONTH_RST;
            base_year_reg  <= cdad_pkg::BASE_YEAR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cdad_pkg::cfg_reg_t'(cfg_index))
                cdad_pkg::REG_BASE_DAY:   base_day_reg   <= cfg_data[cdad_pkg::DAY_W-1:0];
                cdad_pkg::REG_BASE_MONTH: base_month_reg <= cfg_data[cdad_pkg::MONTH_W-1:0];
                cdad_pkg::REG_BASE_YEAR:  base_year_reg  <= cfg_data[cdad_pkg::YEAR_W-1:0];
                default:                  ;  // index beyond the register list: drop
            endcase
        end
    end

    // Working registers
    state_t                           state_reg, state_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;      // remaining day count
    logic [cdad_pkg::MONTH_W-1:0]     month_reg, month_next;
    logic [cdad_pkg::YEAR_W-1:0]      year_reg, year_next;
    logic [cdad_pkg::REM_W-1:0]       rem_reg, rem_next;      // year mod 100
    logic [cdad_pkg::CENT_CNT_W-1:0]  cent_reg, cent_next;    // (year / 100) mod 4
    logic                             out_valid_reg, out_valid_next;
    logic [cdad_pkg::M_TDATA_W-1:0]   out_data_reg, out_data_next;

    logic                             in_xfer;
    logic                             leap;
    logic [cdad_pkg::DAY_W-1:0]       len;
    logic [SUB_W-1:0]                 sub_a, sub_b, sub_diff;
    logic                             sub_borrow;
    logic                             fin;
    logic [cdad_pkg::MONTH_W-1:0]     start_month;

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Leap rule from the century-split year: divisible by 4, and a century year
    // only when its century count is a multiple of four.
    assign leap = (rem_reg[1:0] == 2'b00) &&
                  ((rem_reg != '0) || (cent_reg == '0));
    assign len  = cdad_pkg::month_len(month_reg, leap);

    // Share the subtractor between century reduction and month stepping.
    assign sub_a = (state_reg == S_SETUP) ? SUB_W'(rem_reg) : SUB_W'(cnt_reg);
    assign sub_b = (state_reg == S_SETUP) ? SUB_W'(cdad_pkg::CENTURY) : SUB_W'(len);

    cdad_sub #(
        .W (SUB_W)
    ) u_sub (
        .a      (sub_a),
        .b      (sub_b),
        .diff   (sub_diff),
        .borrow (sub_borrow)
    );

    // Count no longer exceeds the current month: the date is found.
    assign fin = sub_borrow || (sub_diff == '0);

    // Clamp an out-of-range base month into January..December.
    always_comb
    begin
        if (base_month_reg == cdad_pkg::MONTH_NONE)
            start_month = cdad_pkg::JAN;
        else if (base_month_reg > cdad_pkg::DEC)
            start_month = cdad_pkg::DEC;
        else
            start_month = base_month_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        rem_next       = rem_reg;
        cent_next      = cent_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;

        // Drop the result once the downstream side takes it.
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cnt_next   = CNT_W'(base_day_reg) + CNT_W'(s_tdata & OFF_MASK);
                    month_next = start_month;
                    year_next  = base_year_reg;
                    rem_next   = base_year_reg;
                    cent_next  = '0;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                // Strip one century per cycle until the remainder is below 100.
                if (!sub_borrow)
                begin
                    rem_next  = sub_diff[cdad_pkg::REM_W-1:0];
                    cent_next = cent_reg + 1'b1;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (!fin)
                begin
                    // Advance one month and carry into the year after December.
                    cnt_next = sub_diff[CNT_W-1:0];
                    if (month_reg == cdad_pkg::DEC)
                    begin
                        month_next = cdad_pkg::JAN;
                        year_next  = year_reg + 1'b1;
                        if (year_reg == cdad_pkg::YEAR_MAX)
                        begin
                            rem_next  = '0;
                            cent_next = '0;
                        end
                        else if (rem_reg == cdad_pkg::CENTURY_END)
                        begin
                            rem_next  = '0;
                            cent_next = cent_reg + 1'b1;
                        end
                        else
                        begin
                            rem_next = rem_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        month_next = month_reg + 1'b1;
                    end
                end
                else if (!out_valid_reg || m_tready)
                begin
                    // Hold here until the output register is free.
                    out_data_next  = {1'b0, year_reg, month_reg,
                                      cnt_reg[cdad_pkg::DAY_W-1:0]};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        rem_reg   <= rem_next;
        cent_reg  <= cent_next;
    end

`ifndef SYNTHESIS
    a_accept_starts_setup: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == S_SETUP))
        else $error("accepted transfer did not start century reduction");

    a_rem_below_century: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) |-> (rem_reg < cdad_pkg::CENTURY))
        else $error("year remainder not reduced below 100 while stepping");

    a_december_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP && !fin && month_reg == cdad_pkg::DEC)
        |=> (month_reg == cdad_pkg::JAN))
        else $error("month did not wrap from December to January");

    a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_STEP))
        else $error("result appeared outside the month stepping phase");
`endif

endmodule
